/* design/ccct_pkg.sv */
// Package for the cluster cone cull test: register index codes and the
// internal datapath widths shared by the pipeline.
// No dependencies.
package ccct_pkg;

   typedef enum logic [2:0] {
      REG_POINT_X      = 3'd0,
      REG_POINT_Y      = 3'd1,
      REG_POINT_Z      = 3'd2,
      REG_AXIS_X       = 3'd3,
      REG_AXIS_Y       = 3'd4,
      REG_AXIS_Z       = 3'd5,
      REG_CONE_COSINE  = 3'd6,
      REG_BOUND_RADIUS = 3'd7
   } csr_index_type;

   localparam int COORD_W    = 32;  // Q16.16 coordinates and radius
   localparam int AXIS_W     = 16;  // Q1.15 axis and cosine
   localparam int DIFF_W     = 33;  // eye minus point
   localparam int SQ_W       = 65;  // one squared difference, at most 2^64
   localparam int SUM_W      = 66;  // squared distance
   localparam int R2_W       = 64;  // squared radius
   localparam int PROD_W     = 49;  // difference times axis component
   localparam int DOT_W      = 50;  // dot product, signed
   localparam int MAG_W      = 49;  // dot product magnitude
   localparam int DLO_W      = 25;  // low slice of the dot magnitude
   localparam int DHI_W      = MAG_W - DLO_W;
   localparam int C2_W       = 30;  // cosine squared
   localparam int SLO_W      = 33;  // low slice of the squared distance
   localparam int SHI_W      = SUM_W - SLO_W;
   localparam int CSP_W      = 63;  // cosine squared times a distance slice
   localparam int DOT2_W     = 98;  // dot product squared
   localparam int CS_W       = 96;  // cosine squared times squared distance
   localparam int NUM_STAGES = 6;

   localparam logic signed [AXIS_W-1:0] COSINE_MINUS_ONE = 16'sh8000;

endpackage

/* design/cluster_cone_cull_test_unit.sv */
// Cluster back-face cone cull test: six-stage pipeline with config registers.
// Depends on ccct_pkg.
//
// Usage:
//   Write the cone (control point, axis, deviation cosine, bounding radius)
//   through the csr_ channel while no transaction is in flight; csr_ready is
//   always high. Each req_ transaction carries an eye position and an enable
//   bit and produces exactly one rsp_ transaction with the culled flag.
// Throughput: one transaction per cycle while rsp_ready is high. The rate is
//   set by the six-stage datapath (difference, products, sums, split squares,
//   partial product sums, final compare); every stage has its own valid bit.
// Stalls: when rsp_ready is low the output stage holds, and each earlier
//   stage holds only when the stage after it is full, so bubbles close up.
//   req_ready drops only when all stages are occupied.
// Reset: synchronous, active high. It empties the pipeline and loads the
//   register reset values (all zero, deviation cosine at minus one, so
//   nothing is culled until the cone is written).
module cluster_cone_cull_test_unit (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  ccct_pkg::csr_index_type        csr_index,
   input  logic [ccct_pkg::COORD_W-1:0]   csr_data,
   // request
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ccct_pkg::COORD_W-1:0]   req_eye_x,
   input  logic [ccct_pkg::COORD_W-1:0]   req_eye_y,
   input  logic [ccct_pkg::COORD_W-1:0]   req_eye_z,
   input  logic                           req_cull_enable,
   // response
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_culled
);
   import ccct_pkg::*;

   // configuration registers
   logic signed [COORD_W-1:0] point_x_ff, point_y_ff, point_z_ff;
   logic signed [AXIS_W-1:0]  axis_x_ff, axis_y_ff, axis_z_ff;
   logic signed [AXIS_W-1:0]  cone_cosine_ff;
   logic [COORD_W-1:0]        bound_radius_ff;

   // pipeline control
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES:0]   adv;

   // stage 0: differences
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic                     pass0_ff, pass0_in;
   // stage 1: squares and axis products
   logic [SQ_W-1:0]          sqx_ff, sqy_ff, sqz_ff, sqx_in, sqy_in, sqz_in;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic                     pass1_ff;
   // stage 2: sums
   logic [SUM_W-1:0]         s_ff, s_in;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic [R2_W-1:0]          r2_ff, r2_in;
   logic [C2_W-1:0]          c2_ff, c2_in;
   logic signed [2*AXIS_W-1:0] c_sq;
   logic                     pass2_ff;
   // stage 3: split squares and flags
   logic [DOT_W-1:0]         dot_u, dot_abs;
   logic [DHI_W-1:0]         dot_hi;
   logic [DLO_W-1:0]         dot_lo;
   logic [2*DHI_W-1:0]       pp_hh_ff, pp_hh_in;
   logic [DHI_W+DLO_W:0]     pp_hl_ff, pp_hl_in;
   logic [2*DLO_W-1:0]       pp_ll_ff, pp_ll_in;
   logic [CSP_W-1:0]         cs_lo_ff, cs_hi_ff, cs_lo_in, cs_hi_in;
   logic                     s_lt_r2_ff, s_zero_ff, dot_neg3_ff, pass3_ff;
   // stage 4: assembled squares
   logic [DOT2_W-1:0]        dot2_ff, dot2_in;
   logic [CS_W-1:0]          cs_ff, cs_in;
   logic                     keep4_ff, dot_neg4_ff;
   // stage 5: output register
   logic                     culled_ff, culled_in;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_x_ff      <= '0;
         point_y_ff      <= '0;
         point_z_ff      <= '0;
         axis_x_ff       <= '0;
         axis_y_ff       <= '0;
         axis_z_ff       <= '0;
         cone_cosine_ff  <= COSINE_MINUS_ONE;
         bound_radius_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_POINT_X:      point_x_ff      <= csr_data;
            REG_POINT_Y:      point_y_ff      <= csr_data;
            REG_POINT_Z:      point_z_ff      <= csr_data;
            REG_AXIS_X:       axis_x_ff       <= csr_data[AXIS_W-1:0];
            REG_AXIS_Y:       axis_y_ff       <= csr_data[AXIS_W-1:0];
            REG_AXIS_Z:       axis_z_ff       <= csr_data[AXIS_W-1:0];
            REG_CONE_COSINE:  cone_cosine_ff  <= csr_data[AXIS_W-1:0];
            REG_BOUND_RADIUS: bound_radius_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // A stage advances when it is empty or the stage after it advances.
   always_comb begin
      adv[NUM_STAGES] = rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign rsp_culled = culled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---------------- datapath ----------------
   always_comb begin
      // stage 0
      dx_in    = DIFF_W'($signed(req_eye_x)) - DIFF_W'(point_x_ff);
      dy_in    = DIFF_W'($signed(req_eye_y)) - DIFF_W'(point_y_ff);
      dz_in    = DIFF_W'($signed(req_eye_z)) - DIFF_W'(point_z_ff);
      pass0_in = req_cull_enable && (cone_cosine_ff != COSINE_MINUS_ONE);
   end

   function automatic logic [DIFF_W-1:0] mag_diff(input logic [DIFF_W-1:0] v);
      mag_diff = v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
   endfunction

   always_comb begin
      // stage 1
      sqx_in = SQ_W'(mag_diff(dx_ff)) * SQ_W'(mag_diff(dx_ff));
      sqy_in = SQ_W'(mag_diff(dy_ff)) * SQ_W'(mag_diff(dy_ff));
      sqz_in = SQ_W'(mag_diff(dz_ff)) * SQ_W'(mag_diff(dz_ff));
      px_in  = PROD_W'(dx_ff) * PROD_W'(axis_x_ff);
      py_in  = PROD_W'(dy_ff) * PROD_W'(axis_y_ff);
      pz_in  = PROD_W'(dz_ff) * PROD_W'(axis_z_ff);
      // stage 2
      s_in   = SUM_W'(sqx_ff) + SUM_W'(sqy_ff) + SUM_W'(sqz_ff);
      dot_in = DOT_W'(px_ff) + DOT_W'(py_ff) + DOT_W'(pz_ff);
      r2_in  = R2_W'(bound_radius_ff) * R2_W'(bound_radius_ff);
      c_sq   = (2*AXIS_W)'(cone_cosine_ff) * (2*AXIS_W)'(cone_cosine_ff);
      c2_in  = c_sq[C2_W-1:0];
      // stage 3: split the dot magnitude so no dot-square product exceeds 25 x 25 bits
      dot_u    = dot_ff;
      dot_abs  = dot_u[DOT_W-1] ? (~dot_u + DOT_W'(1)) : dot_u;
      dot_hi   = dot_abs[MAG_W-1:DLO_W];
      dot_lo   = dot_abs[DLO_W-1:0];
      pp_hh_in = (2*DHI_W)'(dot_hi) * (2*DHI_W)'(dot_hi);
      pp_hl_in = (DHI_W+DLO_W+1)'(dot_hi) * (DHI_W+DLO_W+1)'(dot_lo);
      pp_ll_in = (2*DLO_W)'(dot_lo) * (2*DLO_W)'(dot_lo);
      cs_lo_in = CSP_W'(c2_ff) * CSP_W'(s_ff[SLO_W-1:0]);
      cs_hi_in = CSP_W'(c2_ff) * CSP_W'(s_ff[SUM_W-1:SLO_W]);
      // stage 4
      dot2_in = (DOT2_W'(pp_hh_ff) << (2 * DLO_W))
              + (DOT2_W'(pp_hl_ff) << (DLO_W + 1))
              + DOT2_W'(pp_ll_ff);
      cs_in   = (CS_W'(cs_hi_ff) << SLO_W) + CS_W'(cs_lo_ff);
      // stage 5: a positive cosine needs dot/|d| < c, a negative one a
      // negative dot whose square exceeds c^2 |d|^2
      if (!cone_cosine_ff[AXIS_W-1]) begin
         culled_in = keep4_ff && (dot_neg4_ff || (dot2_ff < DOT2_W'(cs_ff)));
      end else begin
         culled_in = keep4_ff && dot_neg4_ff && (DOT2_W'(cs_ff) < dot2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         dz_ff    <= dz_in;
         pass0_ff <= pass0_in;
      end
      if (adv[1]) begin
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         sqz_ff   <= sqz_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         pass1_ff <= pass0_ff;
      end
      if (adv[2]) begin
         s_ff     <= s_in;
         dot_ff   <= dot_in;
         r2_ff    <= r2_in;
         c2_ff    <= c2_in;
         pass2_ff <= pass1_ff;
      end
      if (adv[3]) begin
         pp_hh_ff    <= pp_hh_in;
         pp_hl_ff    <= pp_hl_in;
         pp_ll_ff    <= pp_ll_in;
         cs_lo_ff    <= cs_lo_in;
         cs_hi_ff    <= cs_hi_in;
         s_lt_r2_ff  <= s_ff < SUM_W'(r2_ff);
         s_zero_ff   <= (s_ff == '0);
         dot_neg3_ff <= dot_ff[DOT_W-1];
         pass3_ff    <= pass2_ff;
      end
      if (adv[4]) begin
         dot2_ff     <= dot2_in;
         cs_ff       <= cs_in;
         keep4_ff    <= pass3_ff && !s_lt_r2_ff && !s_zero_ff;
         dot_neg4_ff <= dot_neg3_ff;
      end
      if (adv[5]) begin
         culled_ff <= culled_in;
      end
   end

`ifndef SYNTHESIS
   // Request side stalls only when every stage holds a transaction.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&vld_ff))
      else $error("req_ready low with an empty stage");

   // A cosine of minus one never culls.
   a_minus_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cone_cosine_ff == COSINE_MINUS_ONE)) |-> !rsp_culled)
      else $error("culled with deviation cosine at minus one");

   // An eye at the control point or inside the radius never culls.
   a_inside: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[3] && adv[4] && (s_zero_ff || s_lt_r2_ff)) |=> !keep4_ff)
      else $error("eye inside radius kept for culling");
`endif

endmodule
